@@ hdl/vrt_pkg.sv @@
// Shared types and constants for the video register and timing unit.
`timescale 1ns / 1ps

package vrt_pkg;

    localparam int DOT_W  = 9;
    localparam int LINE_W = 9;

    // Raster geometry
    localparam logic [DOT_W:0]    DOTS_PER_LINE = 10'd341;
    localparam logic [DOT_W:0]    SHORT_DOT     = 10'd340;
    localparam logic [DOT_W-1:0]  DOT_RESET     = 9'd341;
    localparam logic [LINE_W-1:0] LINE_RESET    = 9'd260;
    localparam logic [LINE_W-1:0] LAST_LINE     = 9'd261;
    localparam logic [LINE_W-1:0] VBLANK_LINE   = 9'd241;
    localparam logic [DOT_W-1:0]  EVENT_DOT     = 9'd1;

    // Register bits
    localparam logic [7:0] FLAG_VBLANK = 8'h80;
    localparam logic [7:0] FLAG_HIT0   = 8'h40;
    localparam int         CTRL_NMI    = 7;
    localparam int         CTRL_STEP32 = 2;
    localparam logic [7:0] MASK_SHOW   = 8'h18;
    localparam logic [15:0] STEP_WIDE  = 16'd32;
    localparam logic [15:0] STEP_NARROW = 16'd1;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_CTRL    = 3'd0,
        REG_MASK    = 3'd1,
        REG_STATUS  = 3'd2,
        REG_OAMADDR = 3'd3,
        REG_OAMDATA = 3'd4,
        REG_SCROLL  = 3'd5,
        REG_ADDR    = 3'd6,
        REG_DATA    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic vblank_start;
        logic vblank_end;
    } vrt_event_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        vram_write_valid;
        logic [15:0] vram_write_addr;
        logic [7:0]  vram_write_data;
        logic        oam_write_valid;
        logic [7:0]  oam_write_addr;
        logic [7:0]  oam_write_data;
        logic        nmi_raise;
        logic [7:0]  active_scroll_x;
        logic [7:0]  active_scroll_y;
    } vrt_access_t;

    typedef struct packed {
        vrt_access_t       acc;
        logic [LINE_W-1:0] scanline_now;
        logic [DOT_W-1:0]  dot_now;
    } vrt_result_t;

endpackage

@@ hdl/video_register_and_timing_unit_top.sv @@
// Top level of the video register and timing unit: input and result registers.
`timescale 1ns / 1ps

// Usage
//   Item channel (item_valid / item_stall): each transfer carries kind
//   (tick, register read, register write), reg_index and write_data.
//   Result channel (result_valid / result_stall): exactly one result per
//   item, in order: read byte, video memory and object memory write
//   requests, NMI pulse, the counters after the item and the applied scroll.
//   Order: an accepted item waits in the input register; its state update
//   and result are computed in one short pass and written to the result
//   register when the result stage advances, and result_valid then rises.
//   Throughput: one item per cycle while result_stall is low; the dot/line
//   counters and register updates are computed combinationally, so
//   back-to-back ticks and accesses stream without gaps.
//   Stall: while the result register is full and stalled, the input register
//   holds its item and item_stall rises; once the result moves on, both
//   stages advance together with no lost or repeated transfer.
//   Reset (rst_n, asynchronous): state registers clear to zero, the dot counter
//   starts at 341 and the line counter at 260, so the first tick lands on
//   dot 0 of the pre-render line. Both stages come out empty.
module video_register_and_timing_unit_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  kind,
    input  logic [2:0]  reg_index,
    input  logic [7:0]  write_data,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  read_data,
    output logic        vram_write_valid,
    output logic [15:0] vram_write_addr,
    output logic [7:0]  vram_write_data,
    output logic        oam_write_valid,
    output logic [7:0]  oam_write_addr,
    output logic [7:0]  oam_write_data,
    output logic        nmi_raise,
    output logic [8:0]  scanline_now,
    output logic [8:0]  dot_now,
    output logic [7:0]  active_scroll_x,
    output logic [7:0]  active_scroll_y
);

    // input register
    logic              in_valid_reg;
    vrt_pkg::kind_t    kind_reg;
    vrt_pkg::reg_idx_t idx_reg;
    logic [7:0]        data_reg;

    // result register
    logic                 out_valid_reg;
    vrt_pkg::vrt_result_t res_reg, res_next;

    logic                 advance;
    logic                 commit;
    logic                 take;
    logic                 show;
    vrt_pkg::vrt_event_t  events;
    vrt_pkg::vrt_access_t acc;
    logic [vrt_pkg::DOT_W-1:0]  dot_cur;
    logic [vrt_pkg::LINE_W-1:0] line_cur;

    // The result stage moves whenever it is empty or its transfer completes.
    assign advance    = !out_valid_reg || !result_stall;
    assign commit     = in_valid_reg && advance;
    assign item_stall = in_valid_reg && !advance;
    assign take       = item_valid && !item_stall;

    vrt_timing u_timing
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (commit && (kind_reg == vrt_pkg::KIND_TICK)),
        .show     (show),
        .dot_now  (dot_cur),
        .line_now (line_cur),
        .events   (events)
    );

    vrt_regs u_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .commit     (commit),
        .kind       (kind_reg),
        .reg_index  (idx_reg),
        .write_data (data_reg),
        .events     (events),
        .show       (show),
        .acc        (acc)
    );

    always_comb
    begin
        res_next.acc          = acc;
        res_next.scanline_now = line_cur;
        res_next.dot_now      = dot_cur;
    end

    // Hold control state under reset; payload needs none.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (commit)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg <= vrt_pkg::kind_t'(kind);
            idx_reg  <= vrt_pkg::reg_idx_t'(reg_index);
            data_reg <= write_data;
        end
        if (commit)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid     = out_valid_reg;
    assign read_data        = res_reg.acc.read_data;
    assign vram_write_valid = res_reg.acc.vram_write_valid;
    assign vram_write_addr  = res_reg.acc.vram_write_addr;
    assign vram_write_data  = res_reg.acc.vram_write_data;
    assign oam_write_valid  = res_reg.acc.oam_write_valid;
    assign oam_write_addr   = res_reg.acc.oam_write_addr;
    assign oam_write_data   = res_reg.acc.oam_write_data;
    assign nmi_raise        = res_reg.acc.nmi_raise;
    assign scanline_now     = res_reg.scanline_now;
    assign dot_now          = res_reg.dot_now;
    assign active_scroll_x  = res_reg.acc.active_scroll_x;
    assign active_scroll_y  = res_reg.acc.active_scroll_y;

endmodule

@@ hdl/vrt_timing.sv @@
// Dot and scanline counters with frame parity and vblank event decode.
`timescale 1ns / 1ps

module vrt_timing
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       tick,
    input  logic                       show,
    output logic [vrt_pkg::DOT_W-1:0]  dot_now,
    output logic [vrt_pkg::LINE_W-1:0] line_now,
    output vrt_pkg::vrt_event_t        events
);

    logic [vrt_pkg::DOT_W-1:0]  dot_reg,  dot_next;
    logic [vrt_pkg::LINE_W-1:0] line_reg, line_next;
    logic                       odd_reg,  odd_next;
    logic [vrt_pkg::DOT_W:0]    dot_inc;
    logic                       short_end;

    always_comb
    begin
        dot_inc   = {1'b0, dot_reg} + 1'b1;
        short_end = show && odd_reg && (line_reg == vrt_pkg::LAST_LINE) &&
                    (dot_inc >= vrt_pkg::SHORT_DOT);
        dot_next  = dot_reg;
        line_next = line_reg;
        odd_next  = odd_reg;
        events    = '0;
        if (tick)
        begin
            dot_next = dot_inc[vrt_pkg::DOT_W-1:0];
            if ((dot_inc >= vrt_pkg::DOTS_PER_LINE) || short_end)
            begin
                // wrap the line; past the pre-render line start a new frame
                dot_next = '0;
                if (line_reg >= vrt_pkg::LAST_LINE)
                begin
                    line_next = '0;
                    odd_next  = ~odd_reg;
                end
                else
                begin
                    line_next = line_reg + 1'b1;
                end
            end
            events.vblank_start = (line_next == vrt_pkg::VBLANK_LINE) &&
                                  (dot_next == vrt_pkg::EVENT_DOT);
            events.vblank_end   = (line_next == vrt_pkg::LAST_LINE) &&
                                  (dot_next == vrt_pkg::EVENT_DOT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg  <= vrt_pkg::DOT_RESET;
            line_reg <= vrt_pkg::LINE_RESET;
            odd_reg  <= 1'b0;
        end
        else
        begin
            dot_reg  <= dot_next;
            line_reg <= line_next;
            odd_reg  <= odd_next;
        end
    end

    assign dot_now  = dot_next;
    assign line_now = line_next;

endmodule

@@ hdl/vrt_regs.sv @@
// CPU-visible register file, write toggle, memory pointers and scroll latches.
`timescale 1ns / 1ps

module vrt_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                commit,
    input  vrt_pkg::kind_t      kind,
    input  vrt_pkg::reg_idx_t   reg_index,
    input  logic [7:0]          write_data,
    input  vrt_pkg::vrt_event_t events,
    output logic                show,
    output vrt_pkg::vrt_access_t acc
);

    logic [7:0]  file_reg    [8];
    logic [7:0]  file_next   [8];
    logic        toggle_reg,  toggle_next;
    logic [15:0] vptr_reg,    vptr_next;
    logic [7:0]  optr_reg,    optr_next;
    logic [7:0]  pend_x_reg,  pend_x_next;
    logic [7:0]  pend_y_reg,  pend_y_next;
    logic [7:0]  appl_x_reg,  appl_x_next;
    logic [7:0]  appl_y_reg,  appl_y_next;

    assign show = (file_reg[vrt_pkg::REG_MASK] & vrt_pkg::MASK_SHOW) != 8'h00;

    always_comb
    begin
        file_next   = file_reg;
        toggle_next = toggle_reg;
        vptr_next   = vptr_reg;
        optr_next   = optr_reg;
        pend_x_next = pend_x_reg;
        pend_y_next = pend_y_reg;
        appl_x_next = appl_x_reg;
        appl_y_next = appl_y_reg;
        acc         = '0;

        case (kind)
            vrt_pkg::KIND_TICK:
            begin
                if (events.vblank_start)
                begin
                    file_next[vrt_pkg::REG_STATUS] =
                        file_reg[vrt_pkg::REG_STATUS] | vrt_pkg::FLAG_VBLANK;
                    acc.nmi_raise = file_reg[vrt_pkg::REG_CTRL][vrt_pkg::CTRL_NMI];
                end
                if (events.vblank_end)
                begin
                    file_next[vrt_pkg::REG_STATUS] = file_reg[vrt_pkg::REG_STATUS] &
                        ~(vrt_pkg::FLAG_VBLANK | vrt_pkg::FLAG_HIT0);
                    appl_x_next = pend_x_reg;
                    appl_y_next = pend_y_reg;
                end
            end
            vrt_pkg::KIND_READ:
            begin
                acc.read_data = file_reg[reg_index];
                if (reg_index == vrt_pkg::REG_STATUS)
                begin
                    // status read drops vblank and resets the shared toggle
                    toggle_next = 1'b0;
                    file_next[vrt_pkg::REG_STATUS] =
                        file_reg[vrt_pkg::REG_STATUS] & ~vrt_pkg::FLAG_VBLANK;
                end
            end
            vrt_pkg::KIND_WRITE:
            begin
                if (reg_index == vrt_pkg::REG_STATUS)
                begin
                    file_next[vrt_pkg::REG_STATUS] = file_reg[vrt_pkg::REG_STATUS] |
                        (write_data & ~vrt_pkg::FLAG_VBLANK);
                end
                else
                begin
                    file_next[reg_index] = write_data;
                end
                case (reg_index)
                    vrt_pkg::REG_OAMADDR:
                    begin
                        optr_next = write_data;
                    end
                    vrt_pkg::REG_OAMDATA:
                    begin
                        acc.oam_write_valid = 1'b1;
                        acc.oam_write_addr  = optr_reg;
                        acc.oam_write_data  = write_data;
                        optr_next           = optr_reg + 1'b1;
                    end
                    vrt_pkg::REG_SCROLL:
                    begin
                        if (toggle_reg)
                        begin
                            pend_y_next = write_data;
                        end
                        else
                        begin
                            pend_x_next = write_data;
                        end
                        toggle_next = ~toggle_reg;
                    end
                    vrt_pkg::REG_ADDR:
                    begin
                        if (toggle_reg)
                        begin
                            vptr_next = {vptr_reg[15:8], write_data};
                        end
                        else
                        begin
                            vptr_next = {write_data, 8'h00};
                        end
                        toggle_next = ~toggle_reg;
                    end
                    vrt_pkg::REG_DATA:
                    begin
                        acc.vram_write_valid = 1'b1;
                        acc.vram_write_addr  = vptr_reg;
                        acc.vram_write_data  = write_data;
                        vptr_next = vptr_reg +
                            (file_reg[vrt_pkg::REG_CTRL][vrt_pkg::CTRL_STEP32] ?
                             vrt_pkg::STEP_WIDE : vrt_pkg::STEP_NARROW);
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        acc.active_scroll_x = appl_x_next;
        acc.active_scroll_y = appl_y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                file_reg[i] <= 8'h00;
            end
            toggle_reg <= 1'b0;
            vptr_reg   <= '0;
            optr_reg   <= '0;
            pend_x_reg <= '0;
            pend_y_reg <= '0;
            appl_x_reg <= '0;
            appl_y_reg <= '0;
        end
        else if (commit)
        begin
            file_reg   <= file_next;
            toggle_reg <= toggle_next;
            vptr_reg   <= vptr_next;
            optr_reg   <= optr_next;
            pend_x_reg <= pend_x_next;
            pend_y_reg <= pend_y_next;
            appl_x_reg <= appl_x_next;
            appl_y_reg <= appl_y_next;
        end
    end

endmodule
